[rtl/bdq_pkg.sv]
// ============================================================================
// bdq_pkg
// Shared types and constants for the bounded double-ended queue: operation
// and status codes, beat payload structs and controller commands.
// ============================================================================
package bdq_pkg;

    // Default configuration
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed payload field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] popped_value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the request beat
        logic exec;     // update indices, write or read the entry store
        logic load;     // load the response register
    } cmd_t;

endpackage

[rtl/bdq_ctrl.sv]
// ============================================================================
// bdq_ctrl
// Sequencer for the deque: takes one request, steps it through execute and
// response load, and owns the response valid flag.
// ============================================================================
module bdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bdq_pkg::cmd_t cmd
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    // response register can take a new beat this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/bdq_dp.sv]
// ============================================================================
// bdq_dp
// Datapath for the deque: request latch, ring indices, entry count, entry
// store with registered read, and the response register.
// ============================================================================
module bdq_dp #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bdq_pkg::cmd_t cmd,
    input  bdq_pkg::req_t req,
    output bdq_pkg::rsp_t rsp
);
    import bdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] store [DEPTH];

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [IDX_W-1:0]      front_reg;
    logic [IDX_W-1:0]      back_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  pop_ok_reg;
    status_t               status_reg;
    rsp_t                  rsp_reg;

    logic [VALUE_W+DATA_WIDTH-1:0] val_ext;
    logic [VALUE_W+DATA_WIDTH-1:0] rd_ext;
    logic [COUNT_W+CNT_W-1:0]      cnt_ext;
    logic [IDX_W-1:0]              front_prev;
    logic [IDX_W-1:0]              front_succ;
    logic [IDX_W-1:0]              back_prev;
    logic [IDX_W-1:0]              back_succ;
    logic                          is_push;
    logic                          empty;
    logic                          full;
    logic                          do_write;
    logic                          do_pop;
    logic [IDX_W-1:0]              wr_addr;
    logic [IDX_W-1:0]              rd_addr;

    // width adaption of the fixed-width fields
    assign val_ext = {{DATA_WIDTH{1'b0}}, req.value};
    assign rd_ext  = {{VALUE_W{1'b0}}, rd_data_reg};
    assign cnt_ext = {{COUNT_W{1'b0}}, count_reg};

    // ring index neighbors, wrapping at DEPTH
    assign front_prev = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_succ = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
    assign back_prev  = (back_reg == '0) ? LAST_SLOT : back_reg - 1'b1;
    assign back_succ  = (back_reg == LAST_SLOT) ? '0 : back_reg + 1'b1;

    // operation decode
    assign is_push  = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_PUSH_BACK);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign do_write = is_push && !full;
    assign do_pop   = !is_push && !empty;
    assign wr_addr  = (op_reg == OP_PUSH_FRONT) ? front_prev : back_reg;
    assign rd_addr  = (op_reg == OP_POP_FRONT) ? front_reg : back_prev;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req.operation;
            val_reg <= val_ext[DATA_WIDTH-1:0];
        end
    end

    // ring indices and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        front_reg <= front_prev;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        back_reg  <= back_succ;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_reg <= front_succ;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (!empty)
                    begin
                        back_reg  <= back_prev;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // entry store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_write)
        begin
            store[wr_addr] <= val_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    // outcome of the execute step
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pop_ok_reg <= do_pop;
            if (is_push && full)
            begin
                status_reg <= ST_FULL;
            end
            else if (!is_push && empty)
            begin
                status_reg <= ST_EMPTY;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.popped_value <= pop_ok_reg ? rd_ext[VALUE_W-1:0] : '0;
            rsp_reg.status       <= status_reg;
            rsp_reg.count        <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign rsp = rsp_reg;

endmodule

[rtl/bounded_deque.sv]
// Sequencing: a request beat is latched in the capture step, applied to the
// indices and entry store in the execute step and put into the response
// register in the load step, which waits while the previous response is
// held by rsp_stall. No new request is taken until the load step is done,
// so only one request is in flight at a time.
// Reset: asynchronous, active low; indices and count clear to an empty
// queue, entry store contents stay undefined until written.
// ============================================================================
// bounded_deque
// Fixed-depth double-ended queue on a ring buffer: push or pop at either
// end, one response beat per request with popped word, status and count.
// ============================================================================
module bounded_deque #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bdq_pkg::rsp_t rsp
);
    import bdq_pkg::*;

    cmd_t cmd;

    // sequencer
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // storage and index logic
    bdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    // a held response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && rsp_valid) |-> !rsp_stall)
        else $error("response register loaded while stalled");

    // full push reports a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (rsp.count == COUNT_W'(DEPTH)))
        else $error("push on full with count below depth");

    // empty pop reports zero word and zero count
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_EMPTY) |->
        (rsp.count == '0 && rsp.popped_value == '0))
        else $error("pop on empty with nonzero word or count");

endmodule

[tb/bounded_deque_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// bounded_deque_checker
// Passive monitor for the bounded deque: tracks accepted request beats,
// predicts each response with its own ring-buffer deque and compares every
// accepted response beat field by field against the oldest prediction.
// ============================================================================
module bounded_deque_checker #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  bdq_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  bdq_pkg::rsp_t rsp,
    output int            mismatches,
    output int            pending
);
    import bdq_pkg::*;

    localparam logic [VALUE_W-1:0] DATA_MASK =
        (DATA_WIDTH >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((64'd1 << DATA_WIDTH) - 64'd1);

    // Predicted deque contents
    logic [VALUE_W-1:0] slots [DEPTH];
    int                 head;
    int                 tail;
    int                 held;

    rsp_t               expected_rsp_q [$];

    function automatic int step_fwd(int idx);
        return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function automatic int step_bwd(int idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    // Apply one request to the predicted deque, return the response it gives
    function automatic rsp_t deque_apply(req_t r);
        rsp_t res;
        res.popped_value = '0;
        res.status       = ST_OK;
        case (r.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else if (r.operation == OP_PUSH_FRONT)
                begin
                    head        = step_bwd(head);
                    slots[head] = r.value & DATA_MASK;
                    held++;
                end
                else
                begin
                    slots[tail] = r.value & DATA_MASK;
                    tail        = step_fwd(tail);
                    held++;
                end
            end
            default:
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else if (r.operation == OP_POP_FRONT)
                begin
                    res.popped_value = slots[head];
                    head             = step_fwd(head);
                    held--;
                end
                else
                begin
                    tail             = step_bwd(tail);
                    res.popped_value = slots[tail];
                    held--;
                end
            end
        endcase
        res.count = COUNT_W'(held);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Watch both channels; the request side is handled first so a prediction
    // is always queued before its response could be seen
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            head = 0;
            tail = 0;
            held = 0;
            expected_rsp_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(deque_apply(req));

            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("response beat with nothing outstanding",
                                    rsp.popped_value, '0);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.popped_value !== want.popped_value)
                        report_mismatch("popped_value", rsp.popped_value, want.popped_value);
                    if (rsp.status !== want.status)
                        report_mismatch("status", VALUE_W'(rsp.status), VALUE_W'(want.status));
                    if (rsp.count !== want.count)
                        report_mismatch("count", VALUE_W'(rsp.count), VALUE_W'(want.count));
                end
            end
            pending = expected_rsp_q.size();
        end
    end

endmodule

[tb/bounded_deque_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// bounded_deque_tb
// Stimulus and verdict for the bounded deque: a directed pass over empty,
// full and extreme-value cases, then random push/pop traffic shaped to fill,
// drain and wrap the ring, with bursty requests and a stalling receiver.
// ============================================================================
module bounded_deque_tb;
    import bdq_pkg::*;

    localparam int N_RANDOM = 1800;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int   mismatches;
    int   pending;
    int   burst_left;

    bounded_deque uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bounded_deque_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on run length
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Present one request beat and hold it until accepted
    task automatic send_beat(op_t op, logic [VALUE_W-1:0] val);
        req_valid <= 1'b1;
        req       <= '{operation: op, value: val};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Requests go out in bursts with idle gaps between them
    task automatic issue(op_t op, logic [VALUE_W-1:0] val);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
        end
        burst_left--;
        send_beat(op, val);
    endtask

    function automatic op_t make_op(bit push, bit front);
        if (push)
            return front ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return front ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(VALUE_W-1){1'b0}}};
            default: return $urandom;
        endcase
    endfunction

    // Receiver: a long hold-off first so the block backs up into its input,
    // then stretches of varying stall density, including none at all
    initial
    begin
        int pct;
        int stretch;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        rsp_stall <= 1'b1;
        repeat (150)
            @(posedge clk);
        forever
        begin
            stretch = $urandom_range(20, 150);
            case ($urandom_range(0, 9))
                0, 1, 2: pct = 0;
                3, 4, 5: pct = 30;
                6, 7:    pct = 70;
                8:       pct = 95;
                default:
                begin
                    pct     = 100;
                    stretch = $urandom_range(40, 100);
                end
            endcase
            repeat (stretch)
            begin
                rsp_stall <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    // Sender and verdict
    initial
    begin
        int          sent;
        int          seg;
        int          mode;
        int          push_pct;
        bit          push;
        bit          front;
        logic [31:0] pattern;

        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '{operation: OP_PUSH_FRONT, value: '0};
        burst_left = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pops on empty, extremes through both ends, then fill
        // and push on full at both ends
        issue(OP_POP_FRONT, '1);
        issue(OP_POP_BACK, '1);
        issue(OP_PUSH_FRONT, '1);
        issue(OP_PUSH_BACK, '0);
        issue(OP_POP_BACK, '1);
        issue(OP_POP_FRONT, '0);
        for (int i = 0; i < 16; i++)
        begin
            case (i % 4)
                0:       pattern = 32'hFFFF_FFFF;
                1:       pattern = 32'h0000_0000;
                2:       pattern = 32'hAAAA_AAAA;
                default: pattern = 32'h5555_5555;
            endcase
            issue(make_op(1'b1, i[0]), pattern ^ i);
        end
        issue(OP_PUSH_FRONT, 32'h1234_5678);
        issue(OP_PUSH_BACK, 32'h8765_4321);

        // Random: segments biased to fill, drain, balance, act as a stack
        // or act as a FIFO, so the ring wraps and hits both limits often
        sent = 0;
        while (sent < N_RANDOM)
        begin
            mode = $urandom_range(0, 4);
            seg  = $urandom_range(8, 64);
            case (mode)
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            repeat (seg)
            begin
                push  = ($urandom_range(1, 100) <= push_pct);
                front = $urandom_range(0, 1);
                if (mode == 3)
                    front = 1'b1;
                else if (mode == 4)
                    front = !push;
                issue(make_op(push, front), rand_word());
                sent++;
            end
        end
        req_valid <= 1'b0;

        // Let the monitor log the last beat, drain, then allow the
        // pipeline to settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
